FILE: hdl/additive_bilinear_splat_macros.svh
// Assertion macros for the additive bilinear splat block.
// Included by abs_ctrl, the module that carries concurrent checks; no other dependency.
`ifndef ADDITIVE_BILINEAR_SPLAT_MACROS_SVH
`define ADDITIVE_BILINEAR_SPLAT_MACROS_SVH

`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset
`define ABS_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion on the usual clk_i / rst_ni pair
`define ABS_ASSERT_CR(lbl, prop, msg) \
  `ABS_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define ABS_ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ABS_ASSERT_CR(lbl, prop, msg)
`endif

`endif

FILE: hdl/abs_pkg.sv
// Shared types and constants of the additive bilinear splat block.
// Used by abs_datapath, abs_ctrl and additive_bilinear_splat; no dependencies.
package abs_pkg;

  // Field widths
  localparam int unsigned POS_W      = 20;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned AMT_W      = 12;
  localparam int unsigned AMT_FRAC   = 8;
  localparam int unsigned TOUCH_W    = 3;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned PIX_W      = 3 * COL_W;

  // Configuration port
  localparam int unsigned DIM_W      = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 10'd320;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 10'd240;

  // Stream payload widths (packed, rounded up to whole bytes)
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_SPLAT = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic       load;       // latch the accepted item
    logic       decode;     // register integer parts, fractions, bounds
    logic       addr;       // register the base pixel address
    logic       issue;      // start one splat pixel down the pipeline
    logic [1:0] k;          // which of the four pixels
    logic       pix_write;  // single-pixel write
    logic       pix_read;   // single-pixel read
    logic       out_load;   // move the result into the output register
  } abs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            splat_ok;
    logic            pix_ok;
  } abs_status_t;

endpackage

FILE: hdl/abs_datapath.sv
// Datapath of the additive bilinear splat block: decode, weight pipeline,
// frame memory and result register. Depends on abs_pkg; driven by abs_ctrl.
module abs_datapath #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [abs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [abs_pkg::DIM_W-1:0]             cfg_data_i,
  input  logic [abs_pkg::IN_TDATA_W-1:0]        in_tdata_i,
  input  logic [abs_pkg::OP_W-1:0]              in_tuser_i,
  input  abs_pkg::abs_cmd_t                     cmd_i,
  output abs_pkg::abs_status_t                  status_o,
  output logic [abs_pkg::OUT_TDATA_W-1:0]       out_tdata_o,
  output logic [0:0]                            out_tuser_o
);
  import abs_pkg::*;

  localparam int unsigned XI_W  = POS_W - FRAC_BITS;
  localparam int unsigned FW    = FRAC_BITS + 2;
  localparam int unsigned PW1   = 2 * FW + AMT_W + 1;
  localparam int unsigned PW2   = PW1 + COL_W;
  localparam int unsigned SH    = 2 * FRAC_BITS + AMT_FRAC;
  localparam int unsigned CW    = ((XI_W > 13) ? XI_W : 13) + 1;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic signed [FW-1:0] ONE     = FW'(2 ** FRAC_BITS);
  localparam logic [CW-1:0]        MIN_DIM = CW'(2);
  localparam logic [CW-1:0]        MAXW_C  = CW'(MAX_WIDTH);
  localparam logic [CW-1:0]        MAXH_C  = CW'(MAX_HEIGHT);
  localparam logic [AW-1:0]        ROW_A   = AW'(MAX_WIDTH);

  // Saturating add of colour * alpha / 256
  function automatic logic [COL_W-1:0] sat_blend(input logic [COL_W-1:0] base,
                                                 input logic [COL_W-1:0] col,
                                                 input logic [COL_W-1:0] alpha);
    logic [2*COL_W-1:0] prod;
    logic [COL_W:0]     sum;
    prod = col * alpha;
    sum  = {1'b0, base} + {1'b0, prod[2*COL_W-1:COL_W]};
    return sum[COL_W] ? {COL_W{1'b1}} : sum[COL_W-1:0];
  endfunction

  // Configuration registers
  logic [DIM_W-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input item register
  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] px_q, py_q;
  logic [COL_W-1:0] red_q, green_q, blue_q;
  logic [AMT_W-1:0] amt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_tuser_i;
      px_q    <= in_tdata_i[POS_W-1:0];
      py_q    <= in_tdata_i[2*POS_W-1:POS_W];
      red_q   <= in_tdata_i[2*POS_W+COL_W-1:2*POS_W];
      green_q <= in_tdata_i[2*POS_W+2*COL_W-1:2*POS_W+COL_W];
      blue_q  <= in_tdata_i[2*POS_W+3*COL_W-1:2*POS_W+2*COL_W];
      amt_q   <= in_tdata_i[2*POS_W+3*COL_W+AMT_W-1:2*POS_W+3*COL_W];
    end
  end

  // Decode: integer part toward zero, signed fraction, frame bounds
  logic             neg_x, neg_y, fail_x, fail_y;
  logic [POS_W-1:0] abs_x, abs_y;
  logic [XI_W-1:0]  mag_x, mag_y, xi_d, yi_d;
  logic [FRAC_BITS:0] fr_x, fr_y;
  logic signed [FW-1:0] u_d, v_d, ou_d, ov_d;
  logic [CW-1:0]    fw_c, fh_c, wc, hc, xc, yc;
  logic             splat_ok_d, pix_ok_d;

  always_comb begin
    neg_x  = px_q[POS_W-1];
    neg_y  = py_q[POS_W-1];
    abs_x  = neg_x ? (~px_q + 1'b1) : px_q;
    abs_y  = neg_y ? (~py_q + 1'b1) : py_q;
    mag_x  = abs_x[POS_W-1:FRAC_BITS];
    mag_y  = abs_y[POS_W-1:FRAC_BITS];
    // a negative position in (-1,0) truncates to zero and still passes
    fail_x = neg_x && (mag_x != '0);
    fail_y = neg_y && (mag_y != '0);
    xi_d   = neg_x ? '0 : mag_x;
    yi_d   = neg_y ? '0 : mag_y;
    fr_x   = neg_x ? px_q[FRAC_BITS:0] : {1'b0, px_q[FRAC_BITS-1:0]};
    fr_y   = neg_y ? py_q[FRAC_BITS:0] : {1'b0, py_q[FRAC_BITS-1:0]};
    u_d    = $signed({fr_x[FRAC_BITS], fr_x});
    v_d    = $signed({fr_y[FRAC_BITS], fr_y});
    ou_d   = ONE - u_d;
    ov_d   = ONE - v_d;
    // frame size clamped to [2, MAX]
    fw_c   = CW'(frame_width_q);
    fh_c   = CW'(frame_height_q);
    wc     = (fw_c < MIN_DIM) ? MIN_DIM : ((fw_c > MAXW_C) ? MAXW_C : fw_c);
    hc     = (fh_c < MIN_DIM) ? MIN_DIM : ((fh_c > MAXH_C) ? MAXH_C : fh_c);
    xc     = CW'(xi_d);
    yc     = CW'(yi_d);
    splat_ok_d = !fail_x && !fail_y && (xc <= wc - MIN_DIM) && (yc <= hc - MIN_DIM);
    pix_ok_d   = !fail_x && !fail_y && (xc < wc) && (yc < hc);
  end

  logic [XI_W-1:0]      xi_q, yi_q;
  logic signed [FW-1:0] u_q, v_q, ou_q, ov_q;
  logic                 splat_ok_q, pix_ok_q;
  logic [AW-1:0]        base_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      xi_q       <= xi_d;
      yi_q       <= yi_d;
      u_q        <= u_d;
      v_q        <= v_d;
      ou_q       <= ou_d;
      ov_q       <= ov_d;
      splat_ok_q <= splat_ok_d;
      pix_ok_q   <= pix_ok_d;
    end
    if (cmd_i.addr) begin
      base_q <= AW'(AW'(yi_q) * ROW_A) + AW'(xi_q);
    end
  end

  assign status_o.op       = op_q;
  assign status_o.splat_ok = splat_ok_q;
  assign status_o.pix_ok   = pix_ok_q;

  // Splat stage 1: bilinear weight from the two selected factors
  logic signed [FW-1:0]   fa, fb;
  logic signed [2*FW-1:0] wt_q;
  logic [1:0]             k1_q, k2_q;
  logic                   s1_v_q, s2_v_q, s3_v_q;

  assign fa = cmd_i.k[0] ? u_q : ou_q;
  assign fb = cmd_i.k[1] ? v_q : ov_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      wt_q <= fa * fb;
      k1_q <= cmd_i.k;
    end
  end

  // Splat stage 2: weight times amount
  logic signed [PW1-1:0]     prod_q;
  logic signed [AMT_W:0]     amt_s;

  assign amt_s = $signed({1'b0, amt_q});

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      prod_q <= wt_q * amt_s;
      k2_q   <= k1_q;
    end
  end

  // Splat stage 3: alpha = prod*255 >> SH, skip if <= 0, clamp; issue read
  logic signed [PW2-1:0] prod_ext, p255;
  logic                  prod_pos;
  logic [COL_W-1:0]      alpha_d, alpha_q;
  logic [AW-1:0]         addr_k, addr3_q;

  always_comb begin
    prod_ext = PW2'(prod_q);
    p255     = (prod_ext <<< COL_W) - prod_ext;
    prod_pos = !prod_q[PW1-1] && (prod_q != '0);
    if (!prod_pos) begin
      alpha_d = '0;
    end else if (p255[PW2-1:SH+COL_W] != '0) begin
      alpha_d = {COL_W{1'b1}};
    end else begin
      alpha_d = p255[SH+COL_W-1:SH];
    end
    addr_k = base_q + (k2_q[1] ? ROW_A : '0) + AW'(k2_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      alpha_q <= alpha_d;
      addr3_q <= addr_k;
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && (alpha_d != '0);
    end
  end

  // Frame memory: one write port, one registered read port
  logic [PIX_W-1:0] frame_mem_q [DEPTH];
  logic [PIX_W-1:0] rdata_q, wdata, blend;
  logic [AW-1:0]    raddr, waddr;
  logic             re, we;

  assign blend = {sat_blend(rdata_q[3*COL_W-1:2*COL_W], red_q,   alpha_q),
                  sat_blend(rdata_q[2*COL_W-1:COL_W],   green_q, alpha_q),
                  sat_blend(rdata_q[COL_W-1:0],         blue_q,  alpha_q)};
  assign re    = s2_v_q || cmd_i.pix_read;
  assign raddr = s2_v_q ? addr_k : base_q;
  assign we    = s3_v_q || cmd_i.pix_write;
  assign waddr = s3_v_q ? addr3_q : base_q;
  assign wdata = s3_v_q ? blend : {red_q, green_q, blue_q};

  always_ff @(posedge clk_i) begin
    if (we) begin
      frame_mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= frame_mem_q[raddr];
    end
  end

  // Count of pixels changed by the current item
  logic [TOUCH_W-1:0] touched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q <= '0;
    end else if (cmd_i.load) begin
      touched_q <= '0;
    end else if (cmd_i.pix_write) begin
      touched_q <= TOUCH_W'(1);
    end else if (s3_v_q) begin
      touched_q <= touched_q + 1'b1;
    end
  end

  // Result register
  logic [PIX_W-1:0]   out_rgb_q;
  logic [TOUCH_W-1:0] out_touched_q;
  logic               out_oof_q, oof_d, read_ok;

  assign read_ok = (op_q == OP_READ) && pix_ok_q;

  always_comb begin
    case (op_q) inside
      OP_SPLAT:          oof_d = !splat_ok_q;
      OP_WRITE, OP_READ: oof_d = !pix_ok_q;
      default:           oof_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_rgb_q     <= read_ok ? rdata_q : '0;
      out_touched_q <= touched_q;
      out_oof_q     <= oof_d;
    end
  end

  assign out_tdata_o = {{(OUT_TDATA_W - TOUCH_W - PIX_W){1'b0}}, out_touched_q,
                        out_rgb_q[COL_W-1:0], out_rgb_q[2*COL_W-1:COL_W],
                        out_rgb_q[3*COL_W-1:2*COL_W]};
  assign out_tuser_o = out_oof_q;

endmodule

FILE: hdl/abs_ctrl.sv
// Controller of the additive bilinear splat block: sequences each item
// through the datapath. Depends on abs_pkg and the assertion macro header.
`include "additive_bilinear_splat_macros.svh"

module abs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  abs_pkg::abs_status_t status_i,
  output abs_pkg::abs_cmd_t    cmd_o
);
  import abs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_ADDR   = 7'b0000100,
    S_SPLAT  = 7'b0001000,
    S_WRITE  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  // four issues, then the weight pipeline drains
  localparam logic [2:0] SPLAT_LAST = 3'd6;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, slot_free;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign slot_free  = !out_valid_q || m_tready_i;
  assign m_tvalid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.load = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.addr = 1'b1;
        cnt_d      = '0;
        case (status_i.op)
          OP_SPLAT: state_d = status_i.splat_ok ? S_SPLAT : S_DONE;
          OP_WRITE: state_d = status_i.pix_ok ? S_WRITE : S_DONE;
          OP_READ:  state_d = status_i.pix_ok ? S_READ : S_DONE;
          default:  state_d = S_DONE;
        endcase
      end
      S_SPLAT: begin
        cmd_o.issue = !cnt_q[2];
        cmd_o.k     = cnt_q[1:0];
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == SPLAT_LAST) state_d = S_DONE;
      end
      S_WRITE: begin
        cmd_o.pix_write = 1'b1;
        state_d         = S_DONE;
      end
      S_READ: begin
        cmd_o.pix_read = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when taken
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ABS_ASSERT_CR(a_state_onehot, $onehot(state_q), "state register not one-hot")
  `ABS_ASSERT_CR(a_accept_decode, accept |=> (state_q == S_DECODE), "accepted item not decoded")
  `ABS_ASSERT_CR(a_load_free, cmd_o.out_load |-> slot_free, "result overwrites a waiting item")
  `ABS_ASSERT_CR(a_splat_end, ((state_q == S_SPLAT) && (cnt_q == SPLAT_LAST)) |=> (state_q == S_DONE), "splat did not finish")

endmodule

FILE: hdl/additive_bilinear_splat.sv
// Top level of the additive bilinear splat frame store.
// Instantiates abs_ctrl and abs_datapath; depends on abs_pkg.
//
// Usage: requests enter on the s_axis channel (tuser = operation: splat,
// pixel write or pixel read). Every request gives one item on m_axis with
// the read colour, the count of pixels changed and an out-of-frame flag.
// frame_width / frame_height are set through cfg_we_i / cfg_index_i /
// cfg_data_i while the block is idle.
// One item at a time: after decode and address, a splat issues its four
// pixels and drains the weight pipeline, a write or read does its pixel
// access, a dropped request has none; then the result register is loaded.
// Splat time is set by the four pixel read-modify-writes, pipelined behind
// a two-multiplier weight chain through one write and one read port of the
// frame memory. The result appears on m_axis the cycle after it is loaded.
// Reset clears control state and restores the frame size to 320 x 240; the
// frame memory is not cleared and a pixel reads as undefined until written.
// A stalled receiver holds the result; the next item is still accepted and
// processed, and waits before its result is loaded.
module additive_bilinear_splat #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [abs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [abs_pkg::DIM_W-1:0]           cfg_data_i,
  // request channel
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x[19:0], pos_y[39:20], red[47:40], green[55:48], blue[63:56],
  // amount[75:64], zero[79:76]
  input  logic [abs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // operation[1:0]
  input  logic [abs_pkg::OP_W-1:0]            s_axis_tuser,
  // result channel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_red[7:0], read_green[15:8], read_blue[23:16],
  // pixels_touched[26:24], zero[31:27]
  output logic [abs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // out_of_frame[0]
  output logic [0:0]                          m_axis_tuser
);
  import abs_pkg::*;

  abs_cmd_t    cmd;
  abs_status_t status;

  // Sequencer
  abs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic, frame memory and result register
  abs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

endmodule
